### hw/rtl/kpc_pkg.sv
`default_nettype none
package kpc_pkg;

  localparam int unsigned DEB_W = 8;
  localparam int unsigned LONG_W = 16;
  localparam int unsigned GAP_W = 16;
  localparam int unsigned CONF_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd2;
  localparam logic [LONG_W-1:0] LONG_RST     = 16'd500;
  localparam logic [GAP_W-1:0]  GAP_RST      = 16'd100;
  localparam logic [CONF_W-1:0] CONFIRM_RST  = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_GAP      = 2'd2,
    REG_CONFIRM  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HOLD     = 3'd2,
    PH_GAP      = 3'd3,
    PH_CONFIRM  = 3'd4,
    PH_WAITREL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [LONG_W-1:0] long_ticks;
    logic [GAP_W-1:0]  gap_ticks;
    logic [CONF_W-1:0] confirm_ticks;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/kpc_regs.sv
`default_nettype none
module kpc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output kpc_pkg::cfg_t                       cfg
);
  import kpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RST;
      cfg.long_ticks     <= LONG_RST;
      cfg.gap_ticks      <= GAP_RST;
      cfg.confirm_ticks  <= CONFIRM_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_ticks <= cfg_data[DEB_W-1:0];
        REG_LONG:     cfg.long_ticks     <= cfg_data[LONG_W-1:0];
        REG_GAP:      cfg.gap_ticks      <= cfg_data[GAP_W-1:0];
        REG_CONFIRM:  cfg.confirm_ticks  <= cfg_data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/kpc_fsm.sv
`default_nettype none
module kpc_fsm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          key_level,
  input  wire kpc_pkg::cfg_t cfg,
  output kpc_pkg::event_t    ev
);
  import kpc_pkg::*;

  phase_t             phase, phase_next;
  logic [LONG_W-1:0]  hold_count, hold_count_next;
  logic [GAP_W-1:0]   window_count, window_count_next;
  logic [DEB_W-1:0]   short_count, short_count_next;

  logic               low;
  logic [DEB_W-1:0]   short_inc;
  logic [LONG_W-1:0]  hold_inc;
  logic [GAP_W-1:0]   window_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hold_count   <= '0;
      window_count <= '0;
      short_count  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      hold_count   <= hold_count_next;
      window_count <= window_count_next;
      short_count  <= short_count_next;
    end
  end

  // saturating increments
  assign low        = ~key_level;
  assign short_inc  = (&short_count) ? short_count : short_count + 1'b1;
  assign hold_inc   = (&hold_count) ? hold_count : hold_count + 1'b1;
  assign window_inc = (&window_count) ? window_count : window_count + 1'b1;

  always_comb begin
    phase_next        = phase;
    hold_count_next   = hold_count;
    window_count_next = window_count;
    short_count_next  = short_count;
    ev                = EV_NONE;
    unique case (phase)
      PH_DEBOUNCE: begin
        if (!low) begin
          phase_next = PH_IDLE;
        end else begin
          short_count_next = short_inc;
          if (short_inc >= cfg.debounce_ticks) begin
            phase_next      = PH_HOLD;
            hold_count_next = '0;
          end
        end
      end
      PH_HOLD: begin
        if (low) begin
          hold_count_next = hold_inc;
          if (hold_inc >= cfg.long_ticks) begin
            ev         = EV_LONG;
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next        = PH_GAP;
          window_count_next = '0;
        end
      end
      PH_GAP: begin
        window_count_next = window_inc;
        if (low) begin
          short_count_next = DEB_W'(1);
          phase_next = (cfg.confirm_ticks <= CONF_W'(1)) ? PH_WAITREL : PH_CONFIRM;
        end else if (window_inc >= cfg.gap_ticks) begin
          ev         = EV_SINGLE;
          phase_next = PH_IDLE;
        end
      end
      PH_CONFIRM: begin
        window_count_next = window_inc;
        if (low) begin
          short_count_next = short_inc;
          if (short_inc >= cfg.confirm_ticks) begin
            phase_next = PH_WAITREL;
          end
        end else if (window_inc >= cfg.gap_ticks) begin
          ev         = EV_SINGLE;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_GAP;
        end
      end
      PH_WAITREL: begin
        if (!low) begin
          ev         = EV_DOUBLE;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (low) begin
          short_count_next = DEB_W'(1);
          if (cfg.debounce_ticks <= DEB_W'(1)) begin
            phase_next      = PH_HOLD;
            hold_count_next = '0;
          end else begin
            phase_next = PH_DEBOUNCE;
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/kpc_skid.sv
`default_nettype none
module kpc_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire kpc_pkg::event_t push_ev,
  output logic                 can_push,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output kpc_pkg::event_t      press_event
);
  import kpc_pkg::*;

  logic   skid_valid;
  event_t skid_ev;
  logic   pop;

  assign pop      = out_valid & out_ready;
  assign can_push = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: main register takes new data when free, else park it in the skid; a pop refills it from the skid
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        press_event <= push_ev;
      end else begin
        skid_ev <= push_ev;
      end
    end else if (pop && skid_valid) begin
      press_event <= skid_ev;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/key_press_classifier.sv
// Key press classifier: one key sample in, one event out per transfer.
// Each event is registered in the output register, or in the skid while
// an earlier one waits. Throughput: one sample per cycle while the skid
// is empty; this two-entry buffer keeps input open while one result waits.
// Reset: synchronous, active high; phase idle, counters zero, registers
// back to debounce 2, long 500, gap 100, confirm 1, output empty.
`default_nettype none
module key_press_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           key_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          press_event
);
  import kpc_pkg::*;

  cfg_t   cfg;
  event_t ev;
  event_t ev_out;
  logic   step;

  assign step        = in_valid & in_ready;
  assign press_event = ev_out;

  kpc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .key_level (key_level),
    .cfg       (cfg),
    .ev        (ev)
  );

  kpc_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (step),
    .push_ev     (ev),
    .can_push    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .press_event (ev_out)
  );

endmodule
`default_nettype wire

### hw/rtl/kpc_checker.sv
`default_nettype none
module kpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] press_event
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(press_event))
    else $error("stalled result changed");

  // output empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // every sample transfer leaves a result pending in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("sample transfer produced no result");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (.*);
`default_nettype wire
